/* design/inverse_park_to_pwm_compare_unit_macros.svh */
// Assertion macros shared by the inverse Park to PWM compare design.
`ifndef INVERSE_PARK_TO_PWM_COMPARE_UNIT_MACROS_SVH
`define INVERSE_PARK_TO_PWM_COMPARE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IPPC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IPPC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ippc_pkg.sv */
// Constants, types and the sine table for the inverse Park to PWM compare unit.
package ippc_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int COS_OFS     = TABLE_DEPTH / 4;

	localparam logic signed [15:0] SQRT3_HALF = 16'sd28378;

	// quotient bits kept by the divider; anything wider already exceeds any period
	localparam int DIV_BITS = 17;
	localparam int REM_W    = 34;
	localparam int S_DIV0   = 10;
	localparam int NST      = S_DIV0 + DIV_BITS;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	// Taylor divisors (2k)(2k+1)
	localparam logic [63:0] FACT_DIV [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	typedef logic signed [15:0] sine_rom_t [TABLE_DEPTH];

	function automatic sine_rom_t build_sine_table();
		sine_rom_t   tbl;
		logic [63:0] frac;
		logic [1:0]  quad;
		logic [63:0] part;
		logic [63:0] x;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] mag;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			frac = (64'(i) << 32) / TABLE_DEPTH;
			quad = frac[31:30];
			part = frac & (ONE_Q30 - 64'd1);
			if (quad[0])
				part = ONE_Q30 - part;
			x = (part * HALF_PI_Q30) >> 30;
			term = x;
			sum = $signed(x);
			for (int k = 1; k <= 10; k++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / FACT_DIV[k];
				if (k % 2 == 1)
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
			if (sum < 0)
				sum = 0;
			mag = (sum + 64'sd16384) >>> 15;
			if (mag > 64'sd32767)
				mag = 64'sd32767;
			tbl[i] = quad[1] ? 16'(-mag) : 16'(mag);
		end
		return tbl;
	endfunction

	localparam sine_rom_t SINE_TABLE = build_sine_table();

endpackage

/* design/ippc_cmd_if.sv */
// Command channel: voltage commands, rotor angle and bus voltage.
interface ippc_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] volt_d;
	logic signed [15:0] volt_q;
	logic [15:0]        rotor_angle;
	logic [15:0]        bus_voltage;

	modport source(output valid, volt_d, volt_q, rotor_angle, bus_voltage, input ready);
	modport sink(input valid, volt_d, volt_q, rotor_angle, bus_voltage, output ready);
endinterface

/* design/ippc_res_if.sv */
// Result channel: three compare counts and status flags.
interface ippc_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic        clipped;
	logic        bus_fault;

	modport source(output valid, compare_a, compare_b, compare_c, clipped, bus_fault,
		input ready);
	modport sink(input valid, compare_a, compare_b, compare_c, clipped, bus_fault,
		output ready);
endinterface

/* design/ippc_cfg_if.sv */
// Configuration write channel for the PWM period.
interface ippc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* design/inverse_park_to_pwm_compare_unit.sv */
// Inverse Park / Clarke transform producing three PWM compare counts per item.
//
//  channel | dir | transfer when         | payload
//  --------+-----+-----------------------+-----------------------------------------------
//  cmd     | in  | cmd.valid & cmd.ready | volt_d, volt_q, rotor_angle, bus_voltage
//  res     | out | res.valid & res.ready | compare_a/b/c, clipped, bus_fault
//  cfg     | in  | cfg.valid & cfg.ready | data = pwm_period (always ready)
//
// One item per cycle while res.ready is high; 9 arithmetic stages (index, sine ROM,
// products, alpha/beta, sqrt3 product, bus offset, magnitude, period products,
// scale), a 17-stage restoring divider by the bus voltage, one quotient bit each,
// and a final clip stage. Every stage loads when it is empty or its successor loads,
// so bubbles collapse and a stalled result holds while earlier stages keep filling.
// cmd.ready falls only with all stages full. Reset clears valid bits and the period.
module inverse_park_to_pwm_compare_unit (
	input logic clk,
	input logic arst_n,
	ippc_cmd_if.sink   cmd,
	ippc_res_if.source res,
	ippc_cfg_if.sink   cfg
);
	import ippc_pkg::*;

	`include "inverse_park_to_pwm_compare_unit_macros.svh"

	logic [15:0]    pwm_period_q;
	logic [NST:1]   vld_q;
	logic [NST+1:1] en;
	logic [NST:1]   vld_in;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= '0;
		end else if (cfg.valid) begin
			pwm_period_q <= cfg.data;
		end
	end

	// stall chain
	assign en[NST+1] = res.ready;
	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate

	assign vld_in    = {vld_q[NST-1:1], cmd.valid};
	assign cmd.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (en[i])
					vld_q[i] <= vld_in[i];
			end
		end
	end

	// stage 1: table indexes
	logic [31:0]          ang_scaled;
	logic [IDX_W:0]       cidx_sum;
	logic [IDX_W-1:0]     idx_c;
	logic [IDX_W-1:0]     cidx_c;
	logic signed [15:0]   vd_s1, vq_s1;
	logic [15:0]          bus_s1;
	logic [IDX_W-1:0]     idx_s1, cidx_s1;

	always_comb begin
		ang_scaled = 32'(cmd.rotor_angle) * 32'(TABLE_DEPTH);
		idx_c      = IDX_W'(ang_scaled >> 16);
		cidx_sum   = (IDX_W+1)'(idx_c) + (IDX_W+1)'(COS_OFS);
		if (cidx_sum >= (IDX_W+1)'(TABLE_DEPTH))
			cidx_c = IDX_W'(cidx_sum - (IDX_W+1)'(TABLE_DEPTH));
		else
			cidx_c = IDX_W'(cidx_sum);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vd_s1   <= cmd.volt_d;
			vq_s1   <= cmd.volt_q;
			bus_s1  <= cmd.bus_voltage;
			idx_s1  <= idx_c;
			cidx_s1 <= cidx_c;
		end
	end

	// stage 2: sine ROM, two read ports
	logic signed [15:0] vd_s2, vq_s2, sin_s2, cos_s2;
	logic [15:0]        bus_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			vd_s2  <= vd_s1;
			vq_s2  <= vq_s1;
			bus_s2 <= bus_s1;
			sin_s2 <= SINE_TABLE[idx_s1];
			cos_s2 <= SINE_TABLE[cidx_s1];
		end
	end

	// stage 3: rotation products
	logic signed [31:0] p_dc_s3, p_qs_s3, p_ds_s3, p_qc_s3;
	logic [15:0]        bus_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			p_dc_s3 <= vd_s2 * cos_s2;
			p_qs_s3 <= vq_s2 * sin_s2;
			p_ds_s3 <= vd_s2 * sin_s2;
			p_qc_s3 <= vq_s2 * cos_s2;
			bus_s3  <= bus_s2;
		end
	end

	// stage 4: alpha, beta in Q15
	logic signed [32:0] alpha_s4, beta_s4;
	logic [15:0]        bus_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			alpha_s4 <= 33'(p_dc_s3) - 33'(p_qs_s3);
			beta_s4  <= 33'(p_ds_s3) + 33'(p_qc_s3);
			bus_s4   <= bus_s3;
		end
	end

	// stage 5: sqrt(3)/2 * beta
	logic signed [32:0] alpha_s5;
	logic signed [47:0] bt_s5;
	logic [15:0]        bus_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			alpha_s5 <= alpha_s4;
			bt_s5    <= 48'(beta_s4) * 48'(SQRT3_HALF);
			bus_s5   <= bus_s4;
		end
	end

	// stage 6: phase voltages in Q30, offset by half the bus
	logic signed [49:0] a15, a14, bt_x, bus_half;
	logic signed [49:0] w_c [3];
	logic signed [49:0] w_s6 [3];
	logic [15:0]        bus_s6;

	always_comb begin
		a15      = 50'(alpha_s5) <<< 15;
		a14      = 50'(alpha_s5) <<< 14;
		bt_x     = 50'(bt_s5);
		bus_half = $signed({5'd0, bus_s5, 29'd0});
		w_c[0]   = bus_half - a15;
		w_c[1]   = bus_half + a14 - bt_x;
		w_c[2]   = bus_half + a14 + bt_x;
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			w_s6   <= w_c;
			bus_s6 <= bus_s5;
		end
	end

	// stage 7: sign and magnitude
	logic [2:0]  neg_s7;
	logic [47:0] aw_s7 [3];
	logic [15:0] bus_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int p = 0; p < 3; p++) begin
				neg_s7[p] <= w_s6[p][49];
				aw_s7[p]  <= w_s6[p][49] ? 48'(-w_s6[p]) : 48'(w_s6[p]);
			end
			bus_s7 <= bus_s6;
		end
	end

	// stage 8: period times magnitude, two partial products
	logic [39:0] pph_s8 [3];
	logic [39:0] ppl_s8 [3];
	logic [2:0]  neg_s8;
	logic [15:0] bus_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int p = 0; p < 3; p++) begin
				pph_s8[p] <= 40'(pwm_period_q) * 40'(aw_s7[p][47:24]);
				ppl_s8[p] <= 40'(pwm_period_q) * 40'(aw_s7[p][23:0]);
			end
			neg_s8 <= neg_s7;
			bus_s8 <= bus_s7;
		end
	end

	// stage 9: dividend = period * |w| / 2^30
	logic [63:0]      prod_c [3];
	logic [REM_W-1:0] num_s9 [3];
	logic [2:0]       neg_s9;
	logic [15:0]      bus_s9;

	always_comb begin
		for (int p = 0; p < 3; p++)
			prod_c[p] = {pph_s8[p][39:0], 24'd0} + 64'(ppl_s8[p]);
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int p = 0; p < 3; p++)
				num_s9[p] <= prod_c[p][63:30];
			neg_s9 <= neg_s8;
			bus_s9 <= bus_s8;
		end
	end

	// stages 10..26: restoring divider, index j sits in stage S_DIV0 + j
	logic [REM_W-1:0]    div_rem_s10 [DIV_BITS][3];
	logic [DIV_BITS-1:0] div_quo_s10 [DIV_BITS][3];
	logic [2:0]          div_ovf_s10 [DIV_BITS];
	logic [2:0]          div_neg_s10 [DIV_BITS];
	logic [15:0]         div_bus_s10 [DIV_BITS];

	genvar j;
	generate
		for (j = 0; j < DIV_BITS; j++) begin : g_div
			localparam int BIT = DIV_BITS - 1 - j;
			logic [REM_W-1:0]    rem_i [3];
			logic [DIV_BITS-1:0] quo_i [3];
			logic [2:0]          ovf_i;
			logic [2:0]          neg_i;
			logic [15:0]         bus_i;
			logic [REM_W-1:0]    shd;

			if (j == 0) begin : g_first
				always_comb begin
					for (int p = 0; p < 3; p++) begin
						rem_i[p] = num_s9[p];
						quo_i[p] = '0;
						ovf_i[p] = num_s9[p][REM_W-1:DIV_BITS] >=
							(REM_W-DIV_BITS)'(bus_s9);
					end
					neg_i = neg_s9;
					bus_i = bus_s9;
				end
			end else begin : g_next
				always_comb begin
					rem_i = div_rem_s10[j-1];
					quo_i = div_quo_s10[j-1];
					ovf_i = div_ovf_s10[j-1];
					neg_i = div_neg_s10[j-1];
					bus_i = div_bus_s10[j-1];
				end
			end

			assign shd = REM_W'(bus_i) << BIT;

			always_ff @(posedge clk) begin
				if (en[S_DIV0 + j]) begin
					for (int p = 0; p < 3; p++) begin
						if (rem_i[p] >= shd) begin
							div_rem_s10[j][p] <= rem_i[p] - shd;
							div_quo_s10[j][p] <= quo_i[p] | (DIV_BITS'(1) << BIT);
						end else begin
							div_rem_s10[j][p] <= rem_i[p];
							div_quo_s10[j][p] <= quo_i[p];
						end
					end
					div_ovf_s10[j] <= ovf_i;
					div_neg_s10[j] <= neg_i;
					div_bus_s10[j] <= bus_i;
				end
			end
		end
	endgenerate

	// stage 27: clip into [0, period], bus fault override
	logic [15:0]         cmp_c [3];
	logic [2:0]          clp_c;
	logic [DIV_BITS-1:0] q_l;
	logic                ovf_l;
	logic                fault_c;
	logic [15:0]         cmp_s27 [3];
	logic                clip_s27, fault_s27;

	always_comb begin
		fault_c = div_bus_s10[DIV_BITS-1] == 16'd0;
		for (int p = 0; p < 3; p++) begin
			q_l   = div_quo_s10[DIV_BITS-1][p];
			ovf_l = div_ovf_s10[DIV_BITS-1][p];
			if (fault_c) begin
				cmp_c[p] = '0;
				clp_c[p] = 1'b0;
			end else if (div_neg_s10[DIV_BITS-1][p]) begin
				cmp_c[p] = '0;
				clp_c[p] = ovf_l || (q_l != '0);
			end else if (ovf_l || (q_l > DIV_BITS'(pwm_period_q))) begin
				cmp_c[p] = pwm_period_q;
				clp_c[p] = 1'b1;
			end else begin
				cmp_c[p] = q_l[15:0];
				clp_c[p] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			cmp_s27   <= cmp_c;
			clip_s27  <= |clp_c;
			fault_s27 <= fault_c;
		end
	end

	assign res.valid     = vld_q[NST];
	assign res.compare_a = cmp_s27[0];
	assign res.compare_b = cmp_s27[1];
	assign res.compare_c = cmp_s27[2];
	assign res.clipped   = clip_s27;
	assign res.bus_fault = fault_s27;

	`IPPC_ASSERT_NOW(a_fault_zero, clk, arst_n, res.valid && res.bus_fault,
		res.compare_a == 16'd0 && res.compare_b == 16'd0 && res.compare_c == 16'd0 &&
		!res.clipped, "bus fault result with nonzero compare or clip")
	`IPPC_ASSERT_NOW(a_in_range, clk, arst_n, res.valid,
		res.compare_a <= pwm_period_q && res.compare_b <= pwm_period_q &&
		res.compare_c <= pwm_period_q, "compare above PWM period")
	`IPPC_ASSERT_NOW(a_full_stall, clk, arst_n, !cmd.ready, &vld_q,
		"command refused while a pipeline stage is empty")
	`IPPC_ASSERT_NEXT(a_hold_result, clk, arst_n, res.valid && !res.ready,
		res.valid && $stable(res.compare_a) && $stable(res.clipped),
		"stalled result changed")

endmodule
